FILE: rtl/itoa_pkg.sv
package itoa_pkg;

  localparam int unsigned LONG_WIDTH    = 64;
  localparam int unsigned MAX_PRECISION = 63;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DEC_DIGITS = 20;
  localparam int unsigned HEX_DIGITS = VALUE_W / DIGIT_W;
  localparam int unsigned BCD_W      = DEC_DIGITS * DIGIT_W;
  localparam int unsigned LONG_SHIFT = VALUE_W - LONG_WIDTH;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [1:0] WS_INT  = 2'd0;
  localparam logic [1:0] WS_LONG = 2'd1;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         width_select;
    logic               is_hex;
    logic               is_signed;
    logic               upper_case;
    logic               show_sign;
    logic               plus_sign;
    logic               has_precision;
    logic [5:0]         precision;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic hex;
  } conv_ctrl_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_NORM  = 6'b000100,
    ST_SIGN  = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_DIGIT = 6'b100000
  } state_e;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d >= 4'd10) begin
      return base + {4'd0, d} - 8'd10;
    end
    return CH_ZERO + {4'd0, d};
  endfunction

endpackage

FILE: rtl/itoa_conv.sv
module itoa_conv (
  input  logic                         clk_i,
  input  itoa_pkg::conv_ctrl_t         ctrl_i,
  input  logic [itoa_pkg::VALUE_W-1:0] load_value_i,
  output logic [itoa_pkg::BCD_W-1:0]   digits_o
);
  import itoa_pkg::*;

  logic [BCD_W-1:0]   bcd_q;
  logic [BCD_W-1:0]   adj;
  logic [VALUE_W-1:0] shift_q;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      // hex nibbles are already digits
      bcd_q   <= ctrl_i.hex ? {{(BCD_W-VALUE_W){1'b0}}, load_value_i} : '0;
      shift_q <= load_value_i;
    end else if (ctrl_i.step) begin
      bcd_q   <= {adj[BCD_W-2:0], shift_q[VALUE_W-1]};
      shift_q <= {shift_q[VALUE_W-2:0], 1'b0};
    end
  end

  assign digits_o = bcd_q;

endmodule

FILE: rtl/integer_to_ascii_formatter.sv
// integer to ascii formatter
// an item is taken at a clock edge where start is high and busy is low. in_i
// carries the integer and its conversion settings. the text comes out on out_o,
// one character per cycle marked by out_valid_o, most significant character
// first, sign then zero padding then digits; out_o.last marks the final one.
// an item that makes no text (zero with precision zero and no sign) gives no
// strobe at all.
// steps per item: the accept, then for decimal one shift-add-3 pass per operand
// bit (32 or 64 bits) in the shared bcd unit, then the leading zero digits are
// dropped one at a time (up to 19 decimal, 15 hex) and the count settles, then
// the characters go out (up to 64). hex skips the bcd passes.
// each character appears in the cycle after it is produced; busy falls as the
// last character is registered, so the next item may be taken while it shows.
// the receiver cannot stall: each word is valid for exactly one cycle.
// reset clears the sequencer and the strobe; nothing else needs clearing.
module integer_to_ascii_formatter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  itoa_pkg::in_t  in_i,
  output logic           busy,
  output logic           out_valid_o,
  output itoa_pkg::out_t out_o
);
  import itoa_pkg::*;

  state_e state_q, state_d;

  logic [6:0] iter_q, iter_d;
  logic [4:0] nd_q, nd_d;
  logic [5:0] pad_q, pad_d;

  logic       upper_q, has_prec_q, sign_en_q;
  logic [5:0] prec_q;
  logic [7:0] sign_ch_q;

  logic       out_valid_d, out_valid_q;
  out_t       out_d, out_q;

  conv_ctrl_t         conv_ctrl;
  logic [BCD_W-1:0]   digits;
  logic [VALUE_W-1:0] mask, v_masked, mag, load_value;
  logic               sign_bit, neg, accept;
  logic [6:0]         width_bits;
  logic [4:0]         dig_idx;
  logic [3:0]         cur_digit;
  logic [4:0]         nd_fin;
  logic [5:0]         pad_fin;
  logic [5:0]         prec_sat;
  logic [7:0]         sign_ch;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // operand selection and sign handling at load
  always_comb begin
    case (in_i.width_select)
      WS_INT: begin
        mask       = {{32{1'b0}}, {32{1'b1}}};
        width_bits = 7'd32;
        sign_bit   = in_i.value[31];
      end
      WS_LONG: begin
        mask       = {VALUE_W{1'b1}} >> LONG_SHIFT;
        width_bits = 7'(LONG_WIDTH);
        sign_bit   = in_i.value[LONG_WIDTH-1];
      end
      default: begin
        mask       = {VALUE_W{1'b1}};
        width_bits = 7'd64;
        sign_bit   = in_i.value[63];
      end
    endcase
    v_masked = in_i.value & mask;
    neg      = !in_i.is_hex && in_i.is_signed && sign_bit;
    mag      = neg ? ((~v_masked + 64'd1) & mask) : v_masked;
    // line the operand up at the top so each pass takes its next bit
    load_value = in_i.is_hex ? mag : (mag << (7'd64 - width_bits));
    if (neg) begin
      sign_ch = CH_MINUS;
    end else begin
      sign_ch = in_i.plus_sign ? CH_PLUS : CH_SPACE;
    end
    prec_sat = (in_i.precision > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : in_i.precision;
  end

  itoa_conv u_conv (
    .clk_i        (clk_i),
    .ctrl_i       (conv_ctrl),
    .load_value_i (load_value),
    .digits_o     (digits)
  );

  assign conv_ctrl.load = accept;
  assign conv_ctrl.step = (state_q == ST_CONV);
  assign conv_ctrl.hex  = in_i.is_hex;

  assign dig_idx   = nd_q - 5'd1;
  assign cur_digit = digits[{dig_idx, 2'b00} +: DIGIT_W];

  // digit count and zero padding once the leading zeros are gone
  always_comb begin
    if (nd_q == 5'd1 && cur_digit == 4'd0 && has_prec_q) begin
      nd_fin = 5'd0;
    end else begin
      nd_fin = nd_q;
    end
    if (has_prec_q && (prec_q > {1'b0, nd_fin})) begin
      pad_fin = prec_q - {1'b0, nd_fin};
    end else begin
      pad_fin = 6'd0;
    end
  end

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    nd_d        = nd_q;
    pad_d       = pad_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          iter_d  = width_bits;
          nd_d    = in_i.is_hex ? 5'(HEX_DIGITS) : 5'(DEC_DIGITS);
          state_d = in_i.is_hex ? ST_NORM : ST_CONV;
        end
      end
      ST_CONV: begin
        iter_d = iter_q - 7'd1;
        if (iter_q == 7'd1) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (nd_q > 5'd1 && cur_digit == 4'd0) begin
          nd_d = nd_q - 5'd1;
        end else begin
          nd_d  = nd_fin;
          pad_d = pad_fin;
          if (sign_en_q) begin
            state_d = ST_SIGN;
          end else if (pad_fin != 6'd0) begin
            state_d = ST_PAD;
          end else if (nd_fin != 5'd0) begin
            state_d = ST_DIGIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SIGN: begin
        out_valid_d    = 1'b1;
        out_d.out_char = sign_ch_q;
        out_d.last     = (pad_q == 6'd0) && (nd_q == 5'd0);
        if (pad_q != 6'd0) begin
          state_d = ST_PAD;
        end else if (nd_q != 5'd0) begin
          state_d = ST_DIGIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        out_valid_d    = 1'b1;
        out_d.out_char = CH_ZERO;
        out_d.last     = (pad_q == 6'd1) && (nd_q == 5'd0);
        pad_d          = pad_q - 6'd1;
        if (pad_q == 6'd1) begin
          state_d = (nd_q != 5'd0) ? ST_DIGIT : ST_IDLE;
        end
      end
      ST_DIGIT: begin
        out_valid_d    = 1'b1;
        out_d.out_char = digit_char(cur_digit, upper_q);
        out_d.last     = (nd_q == 5'd1);
        nd_d           = nd_q - 5'd1;
        if (nd_q == 5'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    nd_q   <= nd_d;
    pad_q  <= pad_d;
    out_q  <= out_d;
    if (accept) begin
      upper_q    <= in_i.upper_case;
      has_prec_q <= in_i.has_precision;
      prec_q     <= prec_sat;
      sign_en_q  <= !in_i.is_hex && (neg || in_i.show_sign);
      sign_ch_q  <= sign_ch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import itoa_pkg::*;

  localparam logic [1:0] WS_QUAD  = 2'd2;
  localparam logic [1:0] WS_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_WORDS = 500;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start;
  in_t   in_i;
  logic  busy;
  logic  out_valid_o;
  out_t  out_o;

  out_t        expected_chars[$];
  int unsigned mismatch_cnt = 0;
  int unsigned word_cnt = 0;
  int unsigned char_cnt = 0;
  int unsigned silent_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_on = 1'b1;

  integer_to_ascii_formatter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .in_i        (in_i),
    .busy        (busy),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // text the formatter should produce for one word, sign first, then padding, then digits
  function automatic void predict_text(input in_t w);
    int unsigned bits;
    int unsigned prec;
    logic [63:0] mask;
    logic [63:0] mag;
    logic [3:0]  d;
    logic [7:0]  sign_ch;
    logic [7:0]  digs[$];
    logic [7:0]  text[$];
    out_t        o;
    case (w.width_select)
      WS_INT:  bits = 32;
      WS_LONG: bits = LONG_WIDTH;
      default: bits = 64;
    endcase
    mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    mag = w.value & mask;
    prec = w.precision;
    if (prec > MAX_PRECISION) prec = MAX_PRECISION;
    sign_ch = 8'd0;
    if (!w.is_hex) begin
      if (w.is_signed && mag[bits-1]) begin
        mag = (64'd0 - mag) & mask;
        sign_ch = CH_MINUS;
      end else if (w.show_sign) begin
        sign_ch = w.plus_sign ? CH_PLUS : CH_SPACE;
      end
    end
    // zero under a precision prints no digit at all
    if (mag != 0 || !w.has_precision) begin
      do begin
        if (w.is_hex) begin
          d = mag[3:0];
          mag = mag >> 4;
          if (d < 4'd10) digs.push_front(CH_ZERO + {4'd0, d});
          else digs.push_front((w.upper_case ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10);
        end else begin
          d = 4'(mag % 64'd10);
          mag = mag / 64'd10;
          digs.push_front(CH_ZERO + {4'd0, d});
        end
      end while (mag != 0 && digs.size() < DEC_DIGITS);
    end
    if (sign_ch != 8'd0) text.push_back(sign_ch);
    if (w.has_precision) begin
      for (int i = digs.size(); i < prec; i++) text.push_back(CH_ZERO);
    end
    foreach (digs[i]) text.push_back(digs[i]);
    if (text.size() == 0) silent_cnt++;
    foreach (text[i]) begin
      if (i < 64) begin
        o.out_char = text[i];
        o.last = (i == text.size() - 1) || (i == 63);
        expected_chars.push_back(o);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    out_t exp_w;
    if (rst_ni && out_valid_o) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected word: out_char %h last %b", out_o.out_char, out_o.last);
        mismatch_cnt++;
      end else begin
        exp_w = expected_chars.pop_front();
        char_cnt++;
        if (out_o.out_char !== exp_w.out_char) begin
          $error("out_char: expected %h actual %h", exp_w.out_char, out_o.out_char);
          mismatch_cnt++;
        end
        if (out_o.last !== exp_w.last) begin
          $error("last: expected %b actual %b", exp_w.last, out_o.last);
          mismatch_cnt++;
        end
      end
    end
  end

  function automatic in_t make_word(input logic [63:0] v, input logic [1:0] ws,
                                    input logic hex, input logic sgn, input logic upper,
                                    input logic show, input logic plus, input logic hasp,
                                    input logic [5:0] prec);
    in_t w;
    w.value = v;
    w.width_select = ws;
    w.is_hex = hex;
    w.is_signed = sgn;
    w.upper_case = upper;
    w.show_sign = show;
    w.plus_sign = plus;
    w.has_precision = hasp;
    w.precision = prec;
    return w;
  endfunction

  // start is redrawn every cycle until the word is taken
  task automatic send_word(input in_t w);
    in_i <= w;
    do begin
      start <= !(idle_on && ($urandom_range(99) < 26));
      @(posedge clk_i);
    end while (!start || busy);
    predict_text(w);
    word_cnt++;
  endtask

  task automatic test_zero_cases();
    send_word(make_word(64'd0, WS_INT, 0, 0, 0, 0, 0, 0, 6'd0));
    send_word(make_word(64'd0, WS_INT, 0, 1, 0, 0, 0, 1, 6'd0));
    send_word(make_word(64'd0, WS_QUAD, 0, 0, 0, 1, 1, 1, 6'd0));
    send_word(make_word(64'd0, WS_LONG, 0, 1, 0, 1, 0, 1, 6'd63));
    send_word(make_word(64'd0, WS_INT, 1, 0, 0, 0, 0, 0, 6'd0));
    send_word(make_word(64'd0, WS_INT, 1, 0, 1, 0, 0, 1, 6'd5));
  endtask

  task automatic test_widths();
    send_word(make_word('1, WS_QUAD, 0, 0, 0, 0, 0, 0, 6'd0));
    send_word(make_word(64'h8000_0000_0000_0000, WS_QUAD, 0, 1, 0, 0, 0, 0, 6'd0));
    send_word(make_word(64'h0000_0000_8000_0000, WS_INT, 0, 1, 0, 0, 0, 0, 6'd0));
    send_word(make_word(64'hFFFF_FFFF_0000_007B, WS_INT, 0, 1, 0, 0, 0, 0, 6'd0));
    send_word(make_word('1, WS_LONG, 0, 1, 0, 0, 0, 0, 6'd0));
    send_word(make_word('1, WS_SPARE, 0, 0, 0, 0, 0, 0, 6'd0));
    send_word(make_word('1, WS_INT, 0, 0, 0, 0, 0, 0, 6'd0));
  endtask

  task automatic test_hex();
    send_word(make_word(64'hDEAD_BEEF_CAFE_F00D, WS_QUAD, 1, 0, 0, 0, 0, 0, 6'd0));
    send_word(make_word(64'hDEAD_BEEF_CAFE_F00D, WS_QUAD, 1, 1, 1, 1, 1, 0, 6'd0));
    send_word(make_word(64'h0000_0000_0000_00AB, WS_INT, 1, 0, 0, 0, 0, 1, 6'd20));
    send_word(make_word('1, WS_INT, 1, 1, 1, 1, 0, 0, 6'd0));
  endtask

  task automatic test_signs_and_padding();
    send_word(make_word(64'd42, WS_INT, 0, 1, 0, 1, 1, 1, 6'd10));
    send_word(make_word(64'd42, WS_INT, 0, 1, 1, 1, 0, 0, 6'd0));
    send_word(make_word(-64'sd7, WS_QUAD, 0, 1, 0, 1, 1, 1, 6'd25));
    send_word(make_word(64'd123456, WS_LONG, 0, 0, 1, 0, 0, 1, 6'd2));
    send_word(make_word(64'h7FFF_FFFF_FFFF_FFFF, WS_QUAD, 0, 1, 0, 1, 0, 1, 6'd63));
  endtask

  task automatic test_random();
    logic [63:0] v;
    in_t w;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // quiet stretch with back-to-back words
      idle_on = !(n >= 200 && n < 320);
      case ($urandom_range(0, 6))
        0: v = {$urandom, $urandom};
        1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        2: v = $urandom_range(0, 999);
        3: v = 64'd0;
        4: v = '1;
        5: v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        default: v = -($urandom_range(1, 1000));
      endcase
      w = make_word(v, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom),
                    ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 24)));
      send_word(w);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    in_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_cases();
    test_widths();
    test_hex();
    test_signs_and_padding();
    test_random();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d words (%0d with no text) and %0d characters checked",
             word_cnt, silent_cnt, char_cnt);
    $display("decimal and hex, all width selects, signs, padding, zero suppression; %0d errors",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/itoa_pkg.sv
rtl/itoa_conv.sv
rtl/integer_to_ascii_formatter.sv
sim/tb_top.sv
